// File: design/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and constants for the stable priority queue: depth, action
// and error codes, the entry record and the per-cycle command to the cells.
// ----------------------------------------------------------------------------
package spq_pkg;

    // number of cells in the chain
    localparam int QUEUE_DEPTH = 16;
    localparam int COUNT_W     = $clog2(QUEUE_DEPTH + 1);

    localparam int ACT_W  = 2;
    localparam int DATA_W = 8;

    // action codes
    localparam logic [ACT_W-1:0] ACT_PUSH   = 2'd0;
    localparam logic [ACT_W-1:0] ACT_REMOVE = 2'd1;
    localparam logic [ACT_W-1:0] ACT_CLEAR  = 2'd2;

    // error codes
    localparam logic [1:0] ERR_OK    = 2'd0;
    localparam logic [1:0] ERR_FULL  = 2'd1;
    localparam logic [1:0] ERR_EMPTY = 2'd2;

    // one queue entry
    typedef struct packed {
        logic [DATA_W-1:0] prio;
        logic [DATA_W-1:0] thread;
        logic [DATA_W-1:0] index;
    } t_entry;

    // command broadcast to every cell in the same cycle
    typedef struct packed {
        logic   push;
        logic   remove;
        logic   clear;
        t_entry entry;
    } t_cmd;

endpackage

// File: design/spq_cell.sv
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the sorted chain. Holds an entry and its valid bit, and on a
// push or remove takes the new entry or a neighbor's entry.
// ----------------------------------------------------------------------------
module spq_cell (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  spq_pkg::t_cmd   i_cmd,
    input  spq_pkg::t_entry i_left_entry,
    input  logic           i_left_valid,
    input  logic           i_left_lt,
    input  spq_pkg::t_entry i_right_entry,
    input  logic           i_right_valid,
    output spq_pkg::t_entry o_entry,
    output logic           o_valid,
    output logic           o_lt,
    output spq_pkg::t_entry o_next_entry,
    output logic           o_next_valid
);
    import spq_pkg::*;

    t_entry r_entry;
    t_entry n_entry;
    logic   r_valid;
    logic   n_valid;
    logic   w_lt;

    // new entry goes ahead of this slot: slot empty or strictly lower priority
    assign w_lt = !r_valid || (r_entry.prio < i_cmd.entry.prio);

    // next slot contents
    always_comb begin
        n_entry = r_entry;
        n_valid = r_valid;
        priority if (i_cmd.clear) begin
            n_valid = 1'b0;
        end else if (i_cmd.push) begin
            if (w_lt) begin
                n_entry = i_left_lt ? i_left_entry : i_cmd.entry;
                n_valid = r_valid | i_left_valid;
            end
        end else if (i_cmd.remove) begin
            n_entry = i_right_entry;
            n_valid = i_right_valid;
        end
    end

    // valid bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // entry payload
    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry      = r_entry;
    assign o_valid      = r_valid;
    assign o_lt         = w_lt;
    assign o_next_entry = n_entry;
    assign o_next_valid = n_valid;

endmodule

// File: design/stable_priority_queue_top.sv
// ----------------------------------------------------------------------------
// stable_priority_queue_top
// Bounded ready queue kept in descending priority order as a chain of
// cells; equal priorities leave first in, first out.
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+---------------------------
//   in      | input     | i_in_valid/o_in_ready  | action, priority, tag, idx
//   out     | output    | o_out_valid/i_out_ready| head, total, error code
//
// Every cell compares against the new priority in parallel and shifts by
// one, so a beat is taken every cycle unless a result beat is stalled.
// The result shows in the output register in the cycle after the input beat.
// A new beat is taken while the output register is empty or being drained.
// Synchronous reset empties the queue at once; there is no clearing pass.
// ----------------------------------------------------------------------------
module stable_priority_queue_top (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic [spq_pkg::ACT_W-1:0]  i_action,
    input  logic [spq_pkg::DATA_W-1:0] i_priority_req,
    input  logic [spq_pkg::DATA_W-1:0] i_thread_tag,
    input  logic [spq_pkg::DATA_W-1:0] i_entry_index,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic                       o_head_valid,
    output logic [spq_pkg::DATA_W-1:0] o_head_priority,
    output logic [spq_pkg::DATA_W-1:0] o_head_thread,
    output logic [spq_pkg::DATA_W-1:0] o_head_index,
    output logic [spq_pkg::COUNT_W-1:0] o_entry_total,
    output logic [1:0]                 o_error_code
);
    import spq_pkg::*;

    t_entry w_entry      [QUEUE_DEPTH];
    logic   w_valid      [QUEUE_DEPTH];
    logic   w_lt         [QUEUE_DEPTH];
    t_entry w_next_entry [QUEUE_DEPTH];
    logic   w_next_valid [QUEUE_DEPTH];

    t_cmd   w_cmd;
    logic   w_fire;
    logic   w_full;
    logic   w_empty;
    logic [1:0] w_err;

    logic [COUNT_W-1:0] r_count;
    logic [COUNT_W-1:0] n_count;

    logic               r_out_valid;
    logic               r_head_valid;
    t_entry             r_head;
    logic [COUNT_W-1:0] r_total;
    logic [1:0]         r_err;

    // input beat taken when the output register is free
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign w_fire     = i_in_valid && o_in_ready;

    assign w_full  = w_valid[QUEUE_DEPTH-1];
    assign w_empty = !w_valid[0];

    // decode the beat into a cell command
    always_comb begin
        w_cmd.push         = w_fire && (i_action == ACT_PUSH) && !w_full;
        w_cmd.remove       = w_fire && (i_action == ACT_REMOVE) && !w_empty;
        w_cmd.clear        = w_fire && (i_action == ACT_CLEAR);
        w_cmd.entry.prio   = i_priority_req;
        w_cmd.entry.thread = i_thread_tag;
        w_cmd.entry.index  = i_entry_index;
    end

    // error code of the beat
    always_comb begin
        w_err = ERR_OK;
        if ((i_action == ACT_PUSH) && w_full) begin
            w_err = ERR_FULL;
        end else if ((i_action == ACT_REMOVE) && w_empty) begin
            w_err = ERR_EMPTY;
        end
    end

    // chain of cells, slot 0 is the head
    for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
        t_entry w_l_entry;
        logic   w_l_valid;
        logic   w_l_lt;
        t_entry w_r_entry;
        logic   w_r_valid;

        if (g == 0) begin : g_first
            assign w_l_entry = '0;
            assign w_l_valid = 1'b1;
            assign w_l_lt    = 1'b0;
        end else begin : g_mid
            assign w_l_entry = w_entry[g-1];
            assign w_l_valid = w_valid[g-1];
            assign w_l_lt    = w_lt[g-1];
        end

        if (g == QUEUE_DEPTH - 1) begin : g_last
            assign w_r_entry = '0;
            assign w_r_valid = 1'b0;
        end else begin : g_inner
            assign w_r_entry = w_entry[g+1];
            assign w_r_valid = w_valid[g+1];
        end

        spq_cell u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_cmd         (w_cmd),
            .i_left_entry  (w_l_entry),
            .i_left_valid  (w_l_valid),
            .i_left_lt     (w_l_lt),
            .i_right_entry (w_r_entry),
            .i_right_valid (w_r_valid),
            .o_entry       (w_entry[g]),
            .o_valid       (w_valid[g]),
            .o_lt          (w_lt[g]),
            .o_next_entry  (w_next_entry[g]),
            .o_next_valid  (w_next_valid[g])
        );
    end

    // entry count
    always_comb begin
        n_count = r_count;
        priority if (w_cmd.clear) begin
            n_count = '0;
        end else if (w_cmd.push) begin
            n_count = r_count + COUNT_W'(1);
        end else if (w_cmd.remove) begin
            n_count = r_count - COUNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    // output beat valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // output payload, head masked to zero when empty
    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_head_valid <= w_next_valid[0];
            r_head       <= w_next_valid[0] ? w_next_entry[0] : '0;
            r_total      <= n_count;
            r_err        <= w_err;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_head_valid    = r_head_valid;
    assign o_head_priority = r_head.prio;
    assign o_head_thread   = r_head.thread;
    assign o_head_index    = r_head.index;
    assign o_entry_total   = r_total;
    assign o_error_code    = r_err;

endmodule

// File: design/spq_checker.sv
// ----------------------------------------------------------------------------
// spq_checker
// Port-level checks on the result beats of the stable priority queue.
// ----------------------------------------------------------------------------
module spq_checker (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       o_out_valid,
    input  logic                       i_out_ready,
    input  logic                       o_head_valid,
    input  logic [spq_pkg::DATA_W-1:0] o_head_priority,
    input  logic [spq_pkg::DATA_W-1:0] o_head_thread,
    input  logic [spq_pkg::DATA_W-1:0] o_head_index,
    input  logic [spq_pkg::COUNT_W-1:0] o_entry_total,
    input  logic [1:0]                 o_error_code
);
    import spq_pkg::*;

    // head is present exactly when the queue holds entries
    a_head_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_head_valid == (o_entry_total != '0)))
        else $error("head valid disagrees with entry total");

    // an empty queue reports a zero head
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_head_valid) |->
            (o_head_priority == '0 && o_head_thread == '0 && o_head_index == '0))
        else $error("empty queue shows nonzero head");

    // a dropped push leaves the queue full
    a_full_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_error_code == ERR_FULL) |->
            (o_entry_total == COUNT_W'(QUEUE_DEPTH)))
        else $error("full error with queue not full");

    // a remove on empty leaves the queue empty
    a_empty_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_error_code == ERR_EMPTY) |-> (o_entry_total == '0))
        else $error("empty error with entries held");

    // stalled result beat holds its priority, total and error code
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=>
            (o_out_valid && $stable(o_head_priority) && $stable(o_entry_total)
             && $stable(o_error_code)))
        else $error("stalled result beat changed");

endmodule

bind stable_priority_queue_top spq_checker u_spq_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_out_valid     (o_out_valid),
    .i_out_ready     (i_out_ready),
    .o_head_valid    (o_head_valid),
    .o_head_priority (o_head_priority),
    .o_head_thread   (o_head_thread),
    .o_head_index    (o_head_index),
    .o_entry_total   (o_entry_total),
    .o_error_code    (o_error_code)
);
